@@ rtl/ttt_pkg.sv @@
// Package for the tick task timer table.
// Shared constants, enums, payload structs and table entry layout.
// No dependencies.
package ttt_pkg;

    localparam int MAX_SLOTS  = 16;
    localparam int SLOT_W     = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
    localparam int RESULT_CAP = 16;
    localparam int RES_CNT_W  = $clog2(RESULT_CAP + 1);
    localparam int TICK_W     = 16;

    typedef enum logic [2:0] {
        CMD_REGISTER = 3'd0,
        CMD_DELAY    = 3'd1,
        CMD_SLEEP    = 3'd2,
        CMD_WAKEUP   = 3'd3,
        CMD_DELETE   = 3'd4,
        CMD_TICK     = 3'd5,
        CMD_DISPATCH = 3'd6
    } cmd_t;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_READY = 2'd1,
        MODE_SUSP  = 2'd2,
        MODE_SLEEP = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        STAT_OK   = 3'd0,
        STAT_ERR  = 3'd1,
        STAT_FULL = 3'd2,
        STAT_DUE  = 3'd3,
        STAT_NONE = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SINGLE,
        FSM_WALK,
        FSM_FLUSH
    } fsm_t;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [3:0]        slot;
        logic [TICK_W-1:0] tick_count;
        logic [TICK_W-1:0] reload_period;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [3:0] slot_out;
        logic       last;
    } out_item_t;

    typedef struct packed {
        mode_t             mode;
        logic [TICK_W-1:0] ticks;
        logic [TICK_W-1:0] period;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic   wr;
        logic   hit;
        logic   due;
        entry_t entry;
    } alu_res_t;

endpackage

@@ rtl/ttt_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module ttt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  aclk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/ttt_slot_alu.sv @@
// Per-entry update logic: new entry and flags for one command on one slot.
// Depends on ttt_pkg.
module ttt_slot_alu (
    input  logic [2:0]                  cmd,
    input  logic [ttt_pkg::TICK_W-1:0]  tick_count,
    input  logic [ttt_pkg::TICK_W-1:0]  reload_period,
    input  ttt_pkg::entry_t             cur,
    output ttt_pkg::alu_res_t           res
);
    import ttt_pkg::*;

    logic [TICK_W-1:0] dec;

    assign dec = (cur.ticks != '0) ? cur.ticks - 1'b1 : '0;

    always_comb begin
        res       = '0;
        res.entry = cur;
        case (cmd)
            CMD_REGISTER: begin
                res.hit          = (cur.mode == MODE_IDLE);
                res.wr           = res.hit;
                res.entry.mode   = (tick_count != '0) ? MODE_SUSP : MODE_READY;
                res.entry.ticks  = tick_count;
                res.entry.period = reload_period;
            end
            CMD_DELAY: begin
                res.hit         = (cur.mode != MODE_IDLE);
                res.wr          = res.hit;
                res.entry.mode  = MODE_SUSP;
                res.entry.ticks = tick_count;
            end
            CMD_SLEEP: begin
                res.hit         = (cur.mode != MODE_IDLE) && (cur.mode != MODE_SLEEP);
                res.wr          = res.hit;
                res.entry.mode  = MODE_SLEEP;
                res.entry.ticks = '0;
            end
            CMD_WAKEUP: begin
                res.hit         = (cur.mode == MODE_SLEEP);
                res.wr          = res.hit;
                res.entry.mode  = MODE_READY;
                res.entry.ticks = '0;
            end
            CMD_DELETE: begin
                res.hit   = (cur.mode != MODE_IDLE);
                res.wr    = res.hit;
                res.entry = '0;
            end
            CMD_TICK: begin
                res.wr          = (cur.mode == MODE_SUSP);
                res.entry.ticks = dec;
                res.entry.mode  = (dec == '0) ? MODE_READY : MODE_SUSP;
            end
            CMD_DISPATCH: begin
                res.due = (cur.mode == MODE_READY);
                res.wr  = res.due;
                if (cur.period != '0) begin
                    res.entry.mode  = MODE_SUSP;
                    res.entry.ticks = cur.period;
                end else begin
                    res.entry = '0;
                end
            end
            default: begin
                res.wr = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/tick_task_timer_table.sv @@
// Tick task timer table: slot table in RAM with a read-modify-write sequencer.
// Delay, sleep, wakeup, delete: read, update in SINGLE, result from FLUSH; one item at a time.
// Register: walks from slot 0 and stops at the lowest idle slot; a full table walks every slot.
// Tick and dispatch: walk every slot, one table read per cycle while the walk is not stalled;
// dispatch stalls the walk while a due result waits on the downstream side.
// aresetn (synchronous) clears control and per-entry valid bits; ready right away.
module tick_task_timer_table (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ttt_pkg::in_item_t   s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ttt_pkg::out_item_t  m_item
);
    import ttt_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_SLOTS - 1);

    fsm_t                 state_reg, state_next;
    in_item_t             item_reg, item_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [RES_CNT_W-1:0] rcnt_reg, rcnt_next;
    out_item_t            pend_reg, pend_next;
    logic                 pend_vld_reg, pend_vld_next;
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;
    logic [MAX_SLOTS-1:0] vld_reg, vld_next;

    logic                 wr_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic [ENTRY_W-1:0]   rd_data;
    entry_t               cur_entry;
    alu_res_t             alu;
    logic                 push;
    out_item_t            push_item;

    logic at_end, out_free, slot_ok, in_walk, in_single;
    logic dsp_stall, walk_done, cap_hit;

    ttt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (idx_reg),
        .wr_data (alu.entry),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cur_entry = vld_reg[idx_reg] ? entry_t'(rd_data) : '0;

    ttt_slot_alu u_alu (
        .cmd           (item_reg.cmd),
        .tick_count    (item_reg.tick_count),
        .reload_period (item_reg.reload_period),
        .cur           (cur_entry),
        .res           (alu)
    );

    assign s_ready  = (state_reg == FSM_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_item   = m_item_reg;
    assign out_free = !m_valid_reg || m_ready;
    assign at_end   = (idx_reg == LAST_IDX);
    assign cap_hit  = (rcnt_reg == RES_CNT_W'(RESULT_CAP - 1));
    assign slot_ok  = (int'(s_item.slot) < MAX_SLOTS);

    assign in_walk   = (s_item.cmd == CMD_REGISTER) || (s_item.cmd == CMD_TICK)
                    || (s_item.cmd == CMD_DISPATCH);
    assign in_single = ((s_item.cmd == CMD_DELAY) || (s_item.cmd == CMD_SLEEP)
                    || (s_item.cmd == CMD_WAKEUP) || (s_item.cmd == CMD_DELETE)) && slot_ok;

    assign dsp_stall = (state_reg == FSM_WALK) && (item_reg.cmd == CMD_DISPATCH)
                    && alu.due && pend_vld_reg && !out_free;

    always_comb begin
        case (item_reg.cmd)
            CMD_REGISTER: walk_done = alu.hit || at_end;
            CMD_DISPATCH: walk_done = at_end || (alu.due && cap_hit);
            default:      walk_done = at_end;
        endcase
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    if (in_walk) begin
                        state_next = FSM_WALK;
                    end else if (in_single) begin
                        state_next = FSM_SINGLE;
                    end else begin
                        state_next = FSM_FLUSH;
                    end
                end
            end
            FSM_SINGLE: state_next = FSM_FLUSH;
            FSM_WALK: begin
                if (!dsp_stall && walk_done) begin
                    state_next = FSM_FLUSH;
                end
            end
            FSM_FLUSH: begin
                if (out_free) begin
                    state_next = FSM_IDLE;
                end
            end
            default: state_next = FSM_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        item_next     = item_reg;
        idx_next      = idx_reg;
        rcnt_next     = rcnt_reg;
        pend_next     = pend_reg;
        pend_vld_next = pend_vld_reg;
        rd_addr       = idx_reg;
        wr_en         = 1'b0;
        push          = 1'b0;
        push_item     = pend_reg;
        case (state_reg)
            FSM_IDLE: begin
                if (s_valid) begin
                    item_next     = s_item;
                    idx_next      = in_walk ? '0 : SLOT_W'(s_item.slot);
                    rd_addr       = idx_next;
                    rcnt_next     = '0;
                    pend_next     = '{status: STAT_ERR, slot_out: 4'd0, last: 1'b0};
                    pend_vld_next = !in_walk && !in_single;
                end
            end
            FSM_SINGLE: begin
                wr_en         = alu.wr;
                pend_next     = '{status: (alu.hit ? STAT_OK : STAT_ERR),
                                  slot_out: 4'd0, last: 1'b0};
                pend_vld_next = 1'b1;
            end
            FSM_WALK: begin
                if (!dsp_stall) begin
                    wr_en = alu.wr;
                    case (item_reg.cmd)
                        CMD_REGISTER: begin
                            if (alu.hit) begin
                                pend_next     = '{status: STAT_OK, slot_out: 4'(idx_reg),
                                                  last: 1'b0};
                                pend_vld_next = 1'b1;
                            end else if (at_end) begin
                                pend_next     = '{status: STAT_FULL, slot_out: 4'd0,
                                                  last: 1'b0};
                                pend_vld_next = 1'b1;
                            end
                        end
                        CMD_TICK: begin
                            if (at_end) begin
                                pend_next     = '{status: STAT_OK, slot_out: 4'd0,
                                                  last: 1'b0};
                                pend_vld_next = 1'b1;
                            end
                        end
                        CMD_DISPATCH: begin
                            if (alu.due) begin
                                push           = pend_vld_reg;
                                push_item.last = 1'b0;
                                pend_next      = '{status: STAT_DUE, slot_out: 4'(idx_reg),
                                                   last: 1'b0};
                                pend_vld_next  = 1'b1;
                                rcnt_next      = rcnt_reg + 1'b1;
                            end
                        end
                        default: begin
                            pend_vld_next = pend_vld_reg;
                        end
                    endcase
                    if (!walk_done) begin
                        idx_next = SLOT_W'(idx_reg + 1'b1);
                        rd_addr  = idx_next;
                    end
                end
            end
            FSM_FLUSH: begin
                if (out_free) begin
                    push = 1'b1;
                    if (pend_vld_reg) begin
                        push_item.last = 1'b1;
                    end else begin
                        push_item = '{status: STAT_NONE, slot_out: 4'd0, last: 1'b1};
                    end
                end
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        vld_next = vld_reg;
        if (wr_en) begin
            vld_next[idx_reg] = 1'b1;
        end
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (push) begin
            m_valid_next = 1'b1;
            m_item_next  = push_item;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_IDLE;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            vld_reg      <= '0;
            rcnt_reg     <= '0;
            idx_reg      <= '0;
        end else begin
            state_reg    <= state_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
            vld_reg      <= vld_next;
            rcnt_reg     <= rcnt_next;
            idx_reg      <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        pend_reg   <= pend_next;
        m_item_reg <= m_item_next;
    end

endmodule
